// ===== sv/grid_stack_instruction_executor_unit_assert.svh =====
// ---------------------------------------------------------------------------
// grid stack executor assertion macros
// shared property forms used at the end of the top level
// ---------------------------------------------------------------------------
`ifndef GRID_STACK_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH
`define GRID_STACK_INSTRUCTION_EXECUTOR_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define GSIE_ASSERT_IMPL(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("gsie: assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define GSIE_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("gsie: assertion failed");

`endif

// ===== sv/gsie_pkg.sv =====
// ---------------------------------------------------------------------------
// gsie_pkg
// types, constants, decoder and microcode table of the grid stack executor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package gsie_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
   localparam int DATA_W      = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int UA_W        = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DX    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_DY    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_QUOTE = 3'd4;

   // item kinds
   localparam logic KIND_START = 1'b0;

   // instruction characters
   localparam logic [7:0] CH_PLUS    = 8'h2b;
   localparam logic [7:0] CH_STAR    = 8'h2a;
   localparam logic [7:0] CH_MINUS   = 8'h2d;
   localparam logic [7:0] CH_SLASH   = 8'h2f;
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_BAR     = 8'h7c;
   localparam logic [7:0] CH_LOW_R   = 8'h72;
   localparam logic [7:0] CH_UP_R    = 8'h52;
   localparam logic [7:0] CH_UP_L    = 8'h4c;
   localparam logic [7:0] CH_TILDE   = 8'h7e;
   localparam logic [7:0] CH_BANG    = 8'h21;
   localparam logic [7:0] CH_GT      = 8'h3e;
   localparam logic [7:0] CH_LOW_V   = 8'h76;
   localparam logic [7:0] CH_LT      = 8'h3c;
   localparam logic [7:0] CH_CARET   = 8'h5e;
   localparam logic [7:0] CH_LBRACK  = 8'h5b;
   localparam logic [7:0] CH_RBRACK  = 8'h5d;
   localparam logic [7:0] CH_LBRACE  = 8'h7b;
   localparam logic [7:0] CH_RBRACE  = 8'h7d;
   localparam logic [7:0] CH_UNDER   = 8'h5f;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_UP_H    = 8'h48;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_QMARK   = 8'h3f;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_F   = 8'h66;
   localparam logic [7:0] HEX_BASE   = 8'd10;
   localparam logic [7:0] NIBBLE     = 8'h0f;
   localparam logic [7:0] DIR_NEG    = 8'hff;
   localparam logic [7:0] SHIFT_LIM  = 8'd8;

   // microcode addresses
   localparam logic [UA_W-1:0] UA_FIN      = 5'd0;
   localparam logic [UA_W-1:0] UA_IMM      = 5'd1;
   localparam logic [UA_W-1:0] UA_PUSH     = 5'd2;
   localparam logic [UA_W-1:0] UA_BIN      = 5'd3;
   localparam logic [UA_W-1:0] UA_BIN_B    = 5'd4;
   localparam logic [UA_W-1:0] UA_BIN_A    = 5'd5;
   localparam logic [UA_W-1:0] UA_CALC     = 5'd6;
   localparam logic [UA_W-1:0] UA_UN       = 5'd7;
   localparam logic [UA_W-1:0] UA_UN_A     = 5'd8;
   localparam logic [UA_W-1:0] UA_DIV      = 5'd9;
   localparam logic [UA_W-1:0] UA_DIV_B    = 5'd10;
   localparam logic [UA_W-1:0] UA_DIV_A    = 5'd11;
   localparam logic [UA_W-1:0] UA_DIV_GO   = 5'd12;
   localparam logic [UA_W-1:0] UA_DIV_WAIT = 5'd13;
   localparam logic [UA_W-1:0] UA_POP      = 5'd14;
   localparam logic [UA_W-1:0] UA_POP_A    = 5'd15;
   localparam logic [UA_W-1:0] UA_PEEK     = 5'd16;

   typedef enum logic {ST_IDLE, ST_RUN} state_type;

   typedef enum logic [3:0] {
      CL_START, CL_IDLE, CL_NOP, CL_BAD, CL_RIGHT, CL_DOWN, CL_LEFT, CL_UP,
      CL_SKIP, CL_QUOTE, CL_HALT, CL_PUSH, CL_BIN, CL_UN, CL_DIV, CL_PRINT
   } cls_type;

   typedef enum logic [3:0] {
      ALU_IMM, ALU_ADD, ALU_SUB, ALU_MUL, ALU_DIV, ALU_MOD, ALU_AND, ALU_OR,
      ALU_XOR, ALU_SHR, ALU_SHL, ALU_NOT, ALU_LNOT
   } alu_type;

   typedef struct packed {
      cls_type          cls;
      alu_type          alu;
      logic [UA_W-1:0]  entry;
      logic             as_char;
      logic [7:0]       imm;
   } dec_type;

   typedef struct packed {
      logic            rd;        // pop: read top, drop count
      logic            pk;        // peek: read top
      logic            lat_a;
      logic            lat_b;
      logic            div_go;
      logic            wait_div;  // hold here while divider busy
      logic            calc;
      logic            push;
      logic            fin;       // hold here until result register free
      logic [UA_W-1:0] nxt;
   } ucode_type;

   function automatic ucode_type ucode_rom(input logic [UA_W-1:0] addr);
      ucode_type uw;
      uw = '0;
      unique case (addr)
         UA_FIN:      begin uw.fin = 1'b1;                   uw.nxt = UA_FIN;      end
         UA_IMM:      begin uw.calc = 1'b1;                  uw.nxt = UA_PUSH;     end
         UA_PUSH:     begin uw.push = 1'b1;                  uw.nxt = UA_FIN;      end
         UA_BIN:      begin uw.rd = 1'b1;                    uw.nxt = UA_BIN_B;    end
         UA_BIN_B:    begin uw.lat_b = 1'b1; uw.rd = 1'b1;   uw.nxt = UA_BIN_A;    end
         UA_BIN_A:    begin uw.lat_a = 1'b1;                 uw.nxt = UA_CALC;     end
         UA_CALC:     begin uw.calc = 1'b1;                  uw.nxt = UA_PUSH;     end
         UA_UN:       begin uw.rd = 1'b1;                    uw.nxt = UA_UN_A;     end
         UA_UN_A:     begin uw.lat_a = 1'b1;                 uw.nxt = UA_CALC;     end
         UA_DIV:      begin uw.rd = 1'b1;                    uw.nxt = UA_DIV_B;    end
         UA_DIV_B:    begin uw.lat_b = 1'b1; uw.rd = 1'b1;   uw.nxt = UA_DIV_A;    end
         UA_DIV_A:    begin uw.lat_a = 1'b1;                 uw.nxt = UA_DIV_GO;   end
         UA_DIV_GO:   begin uw.div_go = 1'b1;                uw.nxt = UA_DIV_WAIT; end
         UA_DIV_WAIT: begin uw.wait_div = 1'b1;              uw.nxt = UA_CALC;     end
         UA_POP:      begin uw.rd = 1'b1;                    uw.nxt = UA_POP_A;    end
         UA_POP_A:    begin uw.lat_a = 1'b1;                 uw.nxt = UA_FIN;      end
         UA_PEEK:     begin uw.pk = 1'b1;                    uw.nxt = UA_POP_A;    end
         default:     begin uw.fin = 1'b1;                   uw.nxt = UA_FIN;      end
      endcase
      return uw;
   endfunction

   function automatic dec_type decode(input logic kind, input logic [7:0] c,
                                      input logic run, input logic quote);
      dec_type d;
      d.cls     = CL_NOP;
      d.alu     = ALU_IMM;
      d.entry   = UA_FIN;
      d.as_char = 1'b0;
      d.imm     = 8'd0;
      if (kind == KIND_START) begin
         d.cls = CL_START;
      end else if (!run) begin
         d.cls = CL_IDLE;
      end else if (quote && (c != CH_DQUOTE)) begin
         d.cls = CL_PUSH;
         d.imm = c;
      end else if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
         d.cls = CL_PUSH;
         d.imm = 8'(c - CH_ZERO);
      end else if ((c >= CH_LOW_A) && (c <= CH_LOW_F)) begin
         d.cls = CL_PUSH;
         d.imm = 8'((c - CH_LOW_A + HEX_BASE) & NIBBLE);
      end else begin
         unique case (c)
            CH_PLUS:    begin d.cls = CL_BIN; d.alu = ALU_ADD;  end
            CH_STAR:    begin d.cls = CL_BIN; d.alu = ALU_MUL;  end
            CH_MINUS:   begin d.cls = CL_BIN; d.alu = ALU_SUB;  end
            CH_SLASH:   begin d.cls = CL_DIV; d.alu = ALU_DIV;  end
            CH_PERCENT: begin d.cls = CL_DIV; d.alu = ALU_MOD;  end
            CH_AMP:     begin d.cls = CL_BIN; d.alu = ALU_AND;  end
            CH_BAR:     begin d.cls = CL_BIN; d.alu = ALU_OR;   end
            CH_LOW_R:   begin d.cls = CL_BIN; d.alu = ALU_XOR;  end
            CH_UP_R:    begin d.cls = CL_BIN; d.alu = ALU_SHR;  end
            CH_UP_L:    begin d.cls = CL_BIN; d.alu = ALU_SHL;  end
            CH_TILDE:   begin d.cls = CL_UN;  d.alu = ALU_NOT;  end
            CH_BANG:    begin d.cls = CL_UN;  d.alu = ALU_LNOT; end
            CH_GT:      d.cls = CL_RIGHT;
            CH_LOW_V:   d.cls = CL_DOWN;
            CH_LT:      d.cls = CL_LEFT;
            CH_CARET:   d.cls = CL_UP;
            CH_LBRACK:  begin d.cls = CL_PRINT; d.entry = UA_POP; end
            CH_RBRACK:  begin d.cls = CL_PRINT; d.entry = UA_POP; d.as_char = 1'b1; end
            CH_LBRACE:  begin d.cls = CL_PRINT; d.entry = UA_PEEK; end
            CH_RBRACE:  begin d.cls = CL_PRINT; d.entry = UA_PEEK; d.as_char = 1'b1; end
            CH_UNDER:   d.cls = CL_SKIP;
            CH_DQUOTE:  d.cls = CL_QUOTE;
            CH_UP_H:    d.cls = CL_HALT;
            CH_SPACE:   d.cls = CL_NOP;
            CH_QMARK:   d.cls = CL_NOP;
            default:    d.cls = CL_BAD;
         endcase
      end
      unique case (d.cls)
         CL_PUSH: d.entry = UA_IMM;
         CL_BIN:  d.entry = UA_BIN;
         CL_UN:   d.entry = UA_UN;
         CL_DIV:  d.entry = UA_DIV;
         default: ;
      endcase
      return d;
   endfunction

endpackage

// ===== sv/grid_stack_instruction_executor_unit.sv =====
// ---------------------------------------------------------------------------
// grid_stack_instruction_executor_unit
// execute core of a two-dimensional stack language, microcoded
// ---------------------------------------------------------------------------
// req channel: one transfer is a start (tuser 0) or an instruction byte
// (tuser 1) fetched by the caller at the last reported position.
// rsp channel: one transfer per request, giving the next fetch position,
// print value and status flags.
// csr port: csr_we writes csr_wdata into start register csr_addr; write only
// while the unit is idle.
// each request runs a short program from the microcode table, one control
// word per cycle unless held at the divider wait or final step; req_tready
// is high only while no program runs. programs are shortest for moves,
// starts and no-ops, then pushes and prints, then alu ops; divide and modulo
// run longest, where the shift-subtract divider sets the longest program.
// the result sits in an output register; the next request is taken while it
// waits, and that program holds at its final step until the register frees.
// reset (synchronous) empties the stack, clears running and loads the start
// registers with their defaults; the stack memory itself is not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "grid_stack_instruction_executor_unit_assert.svh"

module grid_stack_instruction_executor_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // instr[7:0]
   input  logic [0:0]                      req_tuser,   // kind[0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // next_x[7:0], next_y[15:8], print_valid[16], print_as_char[17],
   // print_value[25:18], running[26], bad_instr[27], stack_fault[28],
   // div_zero[29], zero fill[31:30]
   output logic [31:0]                     rsp_tdata,
   input  logic                            csr_we,
   input  logic [gsie_pkg::CSR_IDX_W-1:0]  csr_addr,
   input  logic [gsie_pkg::DATA_W-1:0]     csr_wdata
);

   import gsie_pkg::*;

   // start registers
   logic [7:0] cfg_x_ff, cfg_y_ff, cfg_dx_ff, cfg_dy_ff;
   logic       cfg_q_ff;

   // machine state
   logic [7:0]       pos_x_ff, pos_y_ff, dir_x_ff, dir_y_ff;
   logic             quote_ff, run_ff;
   logic [CNT_W-1:0] cnt_ff;

   // sequencer
   state_type       state_ff, state_in;
   logic [UA_W-1:0] upc_ff, upc_in;
   ucode_type       uc;
   dec_type         dec;

   // datapath
   cls_type    cls_ff;
   alu_type    alu_ff;
   logic       as_char_ff;
   logic [7:0] a_ff, b_ff, r_ff, r_calc, rd_data;
   logic       empty_ff, fault_ff, dz_ff;

   // divider
   logic       dv_busy_ff;
   logic [2:0] dv_cnt_ff;
   logic [7:0] dv_q_ff, dv_r_ff;
   logic [8:0] dv_t;
   logic       dv_ge;

   // output register
   logic        rsp_valid_ff;
   logic [31:0] rsp_data_ff, rsp_data_in;

   logic             req_fire, out_free, fin_fire, running, stack_full, wr_en;
   logic [CNT_W-1:0] cnt_m1;
   logic [7:0]       dir_x_n, dir_y_n, base_x, base_y, pos_x_n, pos_y_n;
   logic             quote_n, run_n, step, skip;
   logic             pv;

   assign dec        = decode(req_tuser[0], req_tdata, run_ff, quote_ff);
   assign uc         = ucode_rom(upc_ff);
   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign running    = (state_ff == ST_RUN);
   assign fin_fire   = running && uc.fin && out_free;
   assign stack_full = (cnt_ff == CNT_W'(STACK_DEPTH));
   assign cnt_m1     = cnt_ff - CNT_W'(1);
   assign wr_en      = running && uc.push && !stack_full;

   gsie_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (cnt_ff[ADDR_W-1:0]),
      .wr_data (r_ff),
      .rd_addr (cnt_m1[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   // sequencer: step counter with wait and final-step holds
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         upc_ff   <= UA_FIN;
      end else begin
         state_ff <= state_in;
         upc_ff   <= upc_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      upc_in   = upc_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_RUN;
               upc_in   = dec.entry;
            end
         end
         ST_RUN: begin
            if (uc.fin) begin
               if (out_free) state_in = ST_IDLE;
            end else if (!(uc.wait_div && dv_busy_ff)) begin
               upc_in = uc.nxt;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // alu
   always_comb begin
      unique case (alu_ff)
         ALU_ADD:  r_calc = 8'(a_ff + b_ff);
         ALU_SUB:  r_calc = 8'(a_ff - b_ff);
         ALU_MUL:  r_calc = 8'(a_ff * b_ff);
         ALU_DIV:  r_calc = dz_ff ? 8'd0 : dv_q_ff;
         ALU_MOD:  r_calc = dz_ff ? 8'd0 : dv_r_ff;
         ALU_AND:  r_calc = a_ff & b_ff;
         ALU_OR:   r_calc = a_ff | b_ff;
         ALU_XOR:  r_calc = a_ff ^ b_ff;
         ALU_SHR:  r_calc = (b_ff < SHIFT_LIM) ? (a_ff >> b_ff[2:0]) : 8'd0;
         ALU_SHL:  r_calc = (b_ff < SHIFT_LIM) ? 8'(a_ff << b_ff[2:0]) : 8'd0;
         ALU_NOT:  r_calc = ~a_ff;
         ALU_LNOT: r_calc = (a_ff == 8'd0) ? 8'd1 : 8'd0;
         default:  r_calc = b_ff;   // immediate push
      endcase
   end

   assign dv_t  = {dv_r_ff, dv_q_ff[7]};
   assign dv_ge = (dv_t >= {1'b0, b_ff});

   // final step: direction, mode and pointer update, and the response word
   always_comb begin
      dir_x_n = dir_x_ff;
      dir_y_n = dir_y_ff;
      quote_n = quote_ff;
      run_n   = run_ff;
      step    = 1'b1;
      skip    = 1'b0;
      base_x  = pos_x_ff;
      base_y  = pos_y_ff;
      unique case (cls_ff)
         CL_START: begin
            dir_x_n = cfg_dx_ff;
            dir_y_n = cfg_dy_ff;
            quote_n = cfg_q_ff;
            run_n   = 1'b1;
            step    = 1'b0;
            base_x  = cfg_x_ff;
            base_y  = cfg_y_ff;
         end
         CL_IDLE:  step = 1'b0;
         CL_RIGHT: begin dir_x_n = 8'd1;    dir_y_n = 8'd0;    end
         CL_DOWN:  begin dir_x_n = 8'd0;    dir_y_n = 8'd1;    end
         CL_LEFT:  begin dir_x_n = DIR_NEG; dir_y_n = 8'd0;    end
         CL_UP:    begin dir_x_n = 8'd0;    dir_y_n = DIR_NEG; end
         CL_SKIP:  skip = 1'b1;
         CL_QUOTE: quote_n = !quote_ff;
         CL_HALT:  run_n = 1'b0;
         default: ;
      endcase
      pos_x_n = 8'(base_x + (step ? dir_x_n : 8'd0) + (skip ? dir_x_n : 8'd0));
      pos_y_n = 8'(base_y + (step ? dir_y_n : 8'd0) + (skip ? dir_y_n : 8'd0));
      pv      = (cls_ff == CL_PRINT);
      rsp_data_in = {2'b00, dz_ff, fault_ff, (cls_ff == CL_BAD), run_n,
                     (pv ? a_ff : 8'd0), (pv && as_char_ff), pv, pos_y_n, pos_x_n};
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_x_ff     <= 8'd0;
         cfg_y_ff     <= 8'd0;
         cfg_dx_ff    <= 8'd1;
         cfg_dy_ff    <= 8'd0;
         cfg_q_ff     <= 1'b0;
         pos_x_ff     <= 8'd0;
         pos_y_ff     <= 8'd0;
         dir_x_ff     <= 8'd1;
         dir_y_ff     <= 8'd0;
         quote_ff     <= 1'b0;
         run_ff       <= 1'b0;
         cnt_ff       <= '0;
         fault_ff     <= 1'b0;
         dz_ff        <= 1'b0;
         empty_ff     <= 1'b0;
         dv_busy_ff   <= 1'b0;
         dv_cnt_ff    <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_addr)
               CSR_START_X:     cfg_x_ff  <= csr_wdata;
               CSR_START_Y:     cfg_y_ff  <= csr_wdata;
               CSR_START_DX:    cfg_dx_ff <= csr_wdata;
               CSR_START_DY:    cfg_dy_ff <= csr_wdata;
               CSR_START_QUOTE: cfg_q_ff  <= csr_wdata[0];
               default: ;
            endcase
         end

         if (req_fire) begin
            fault_ff <= 1'b0;
            dz_ff    <= 1'b0;
         end

         if (running) begin
            if (uc.rd || uc.pk) begin
               if (cnt_ff == '0) begin
                  fault_ff <= 1'b1;
                  empty_ff <= 1'b1;
               end else begin
                  empty_ff <= 1'b0;
                  if (uc.rd) cnt_ff <= cnt_m1;
               end
            end
            if (uc.div_go) begin
               dv_busy_ff <= 1'b1;
               dv_cnt_ff  <= 3'd0;
               if (b_ff == 8'd0) dz_ff <= 1'b1;
            end
            if (uc.push) begin
               // a push onto a full stack is dropped
               if (stack_full) fault_ff <= 1'b1;
               else            cnt_ff   <= cnt_ff + CNT_W'(1);
            end
            if (fin_fire) begin
               pos_x_ff <= pos_x_n;
               pos_y_ff <= pos_y_n;
               dir_x_ff <= dir_x_n;
               dir_y_ff <= dir_y_n;
               quote_ff <= quote_n;
               run_ff   <= run_n;
               if (cls_ff == CL_START) cnt_ff <= '0;
            end
         end

         if (dv_busy_ff) begin
            dv_cnt_ff <= dv_cnt_ff + 3'd1;
            if (dv_cnt_ff == 3'd7) dv_busy_ff <= 1'b0;
         end

         if (fin_fire)        rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         cls_ff     <= dec.cls;
         alu_ff     <= dec.alu;
         as_char_ff <= dec.as_char;
         b_ff       <= dec.imm;
      end
      if (running) begin
         // an empty read yields zero
         if (uc.lat_a) a_ff <= empty_ff ? 8'd0 : rd_data;
         if (uc.lat_b) b_ff <= empty_ff ? 8'd0 : rd_data;
         if (uc.calc)  r_ff <= r_calc;
         if (uc.div_go) begin
            dv_q_ff <= a_ff;
            dv_r_ff <= 8'd0;
         end
      end
      if (dv_busy_ff) begin
         dv_r_ff <= dv_ge ? 8'(dv_t - {1'b0, b_ff}) : dv_t[7:0];
         dv_q_ff <= {dv_q_ff[6:0], dv_ge};
      end
      if (fin_fire) rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   `GSIE_ASSERT_IMPL(a_cnt_range, 1'b1, cnt_ff <= CNT_W'(STACK_DEPTH))
   `GSIE_ASSERT_NEXT(a_accept_runs, req_fire, state_ff == ST_RUN)
   `GSIE_ASSERT_IMPL(a_div_in_run, dv_busy_ff, running && (cls_ff == CL_DIV))
   `GSIE_ASSERT_IMPL(a_rsp_from_fin, $rose(rsp_valid_ff), $past(fin_fire))

endmodule

// ===== sv/gsie_ram.sv =====
// ---------------------------------------------------------------------------
// gsie_ram
// generic single write, single read memory with registered read data
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module gsie_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 64,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
